@@ rtl/cartridge_bank_mapper_assert.svh @@
// Assertion macros for the checker of this block.
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cartridge_bank_mapper: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cartridge_bank_mapper: assertion failed");

`endif

@@ rtl/cbm_pkg.sv @@
`timescale 1ns / 1ps

package cbm_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_CODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_PRESENT = 1'd1;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_BOOT = 3'd1,
        TGT_ROM  = 3'd2,
        TGT_RAM  = 3'd3,
        TGT_CLK  = 3'd4
    } t_target;

    // Clock register indexes
    localparam logic [2:0] CLK_SEC  = 3'd0;
    localparam logic [2:0] CLK_MIN  = 3'd1;
    localparam logic [2:0] CLK_HOUR = 3'd2;

    localparam logic [3:0]  RAM_EN_KEY    = 4'hA;
    localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
    localparam logic [8:0]  ROM_BANK_RST  = 9'd1;

    typedef struct packed {
        logic        op;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_access;

    typedef struct packed {
        t_target     target;
        logic [22:0] phys_address;
        logic        ram_write_strobe;
        logic [7:0]  store_byte;
        logic        force_high_nibble;
        logic        latch_pulse;
    } t_result;

    function automatic logic is_mbc2(input logic [7:0] code);
        return (code == 8'h05) || (code == 8'h06);
    endfunction

    function automatic logic is_mbc3(input logic [7:0] code);
        return (code >= 8'h0F) && (code <= 8'h13);
    endfunction

    function automatic logic is_mbc5(input logic [7:0] code);
        return (code >= 8'h19) && (code <= 8'h1E);
    endfunction

endpackage

@@ rtl/cbm_if.sv @@
`timescale 1ns / 1ps

interface cbm_access_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;

    modport source (output valid, output op, output bus_address, output write_byte,
                    input ready);
    modport sink   (input valid, input op, input bus_address, input write_byte,
                    output ready);
endinterface

interface cbm_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [22:0] phys_address;
    logic        ram_write_strobe;
    logic [7:0]  store_byte;
    logic        force_high_nibble;
    logic        latch_pulse;

    modport source (output valid, output target, output phys_address,
                    output ram_write_strobe, output store_byte,
                    output force_high_nibble, output latch_pulse, input ready);
    modport sink   (input valid, input target, input phys_address,
                    input ram_write_strobe, input store_byte,
                    input force_high_nibble, input latch_pulse, output ready);
endinterface

@@ rtl/cbm_in_reg.sv @@
`timescale 1ns / 1ps

module cbm_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cbm_access_if.sink       i_access,
    input  logic             i_take,
    output logic             o_valid,
    output cbm_pkg::t_access o_item
);

    logic             r_valid;
    cbm_pkg::t_access r_item;

    assign i_access.ready = !r_valid || i_take;
    assign o_valid        = r_valid;
    assign o_item         = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_access.valid && i_access.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_access.valid && i_access.ready) begin
            r_item.op          <= i_access.op;
            r_item.bus_address <= i_access.bus_address;
            r_item.write_byte  <= i_access.write_byte;
        end
    end

endmodule

@@ rtl/cbm_core.sv @@
`timescale 1ns / 1ps

module cbm_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_fire,
    input  cbm_pkg::t_access                    i_item,
    output cbm_pkg::t_result                    o_res
);

    logic [7:0] r_mapper_code;
    logic       r_ram_present;
    logic [8:0] r_rom_bank;
    logic [3:0] r_ram_bank;
    logic       r_ram_enable;
    logic [7:0] r_last_latch_byte;
    logic       r_boot_overlay;

    logic [8:0] n_rom_bank;
    logic [3:0] n_ram_bank;
    logic       n_ram_enable;
    logic [7:0] n_last_latch_byte;
    logic       n_boot_overlay;

    logic [15:0] a;
    logic [7:0]  v;
    logic        wr;
    logic        mbc2;
    logic        mbc3;
    logic        mbc5;
    logic        clk_sel;
    logic [2:0]  clk_idx;
    logic [6:0]  low_bits;
    logic [8:0]  low_bank;

    assign a    = i_item.bus_address;
    assign v    = i_item.write_byte;
    assign wr   = i_item.op;
    assign mbc2 = cbm_pkg::is_mbc2(r_mapper_code);
    assign mbc3 = cbm_pkg::is_mbc3(r_mapper_code);
    assign mbc5 = cbm_pkg::is_mbc5(r_mapper_code);

    // banks 8..12 map to clock registers 0..4; dropping bit 3 subtracts 8
    assign clk_sel = (r_ram_bank >= 4'h8) && (r_ram_bank <= 4'hC);
    assign clk_idx = r_ram_bank[2:0];

    assign low_bits = mbc3 ? v[6:0] : {2'b00, v[4:0]};
    assign low_bank = (low_bits == 7'd0) ? cbm_pkg::ROM_BANK_RST : {2'b00, low_bits};

    always_comb begin
        n_rom_bank        = r_rom_bank;
        n_ram_bank        = r_ram_bank;
        n_ram_enable      = r_ram_enable;
        n_last_latch_byte = r_last_latch_byte;
        n_boot_overlay    = r_boot_overlay;
        o_res             = '0;

        if (a[15:13] == 3'b101) begin
            if (r_ram_enable && r_ram_present) begin
                if (mbc2) begin
                    o_res.target       = cbm_pkg::TGT_RAM;
                    o_res.phys_address = {14'd0, a[8:0]};
                    o_res.store_byte   = {4'h0, v[3:0]};
                    o_res.force_high_nibble = !wr;
                end else if (mbc3 && clk_sel) begin
                    o_res.target       = cbm_pkg::TGT_CLK;
                    o_res.phys_address = {20'd0, clk_idx};
                    case (clk_idx)
                        cbm_pkg::CLK_SEC:  o_res.store_byte = {2'b00, v[5:0]};
                        cbm_pkg::CLK_MIN:  o_res.store_byte = {2'b00, v[5:0]};
                        cbm_pkg::CLK_HOUR: o_res.store_byte = {3'b000, v[4:0]};
                        default:           o_res.store_byte = v;
                    endcase
                end else begin
                    o_res.target       = cbm_pkg::TGT_RAM;
                    o_res.phys_address = {6'd0, r_ram_bank, a[12:0]};
                    o_res.store_byte   = v;
                end
                o_res.ram_write_strobe = wr;
                if (!wr) begin
                    o_res.store_byte = 8'h00;
                end
            end
        end else if (!wr) begin
            if ((a[15:8] == 8'h00) && r_boot_overlay) begin
                o_res.target       = cbm_pkg::TGT_BOOT;
                o_res.phys_address = {7'd0, a};
            end else if (a[15:14] == 2'b00) begin
                o_res.target       = cbm_pkg::TGT_ROM;
                o_res.phys_address = {7'd0, a};
            end else if (a[15:14] == 2'b01) begin
                o_res.target       = cbm_pkg::TGT_ROM;
                o_res.phys_address = {r_rom_bank, a[13:0]};
            end
        end else if (a[15:13] == 3'b000) begin
            n_ram_enable = (v[3:0] == cbm_pkg::RAM_EN_KEY);
        end else if (a[15:12] == 4'h2) begin
            n_rom_bank = mbc5 ? {r_rom_bank[8], v} : low_bank;
        end else if (a[15:12] == 4'h3) begin
            n_rom_bank = mbc5 ? {v[0], r_rom_bank[7:0]} : low_bank;
        end else if (a[15:13] == 3'b010) begin
            if (mbc5) begin
                n_ram_bank = v[3:0];
            end else if (mbc3 && ((v <= 8'h03) || ((v >= 8'h08) && (v <= 8'h0C)))) begin
                n_ram_bank = v[3:0];
            end
        end else if (a[15:13] == 3'b011) begin
            if (mbc3) begin
                o_res.latch_pulse = (r_last_latch_byte == 8'h00) && (v == 8'h01);
                n_last_latch_byte = v;
            end
        end else if (a == cbm_pkg::BOOT_OFF_ADDR) begin
            if (v[0]) begin
                n_boot_overlay = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_code     <= 8'h00;
            r_ram_present     <= 1'b0;
            r_rom_bank        <= cbm_pkg::ROM_BANK_RST;
            r_ram_bank        <= 4'h0;
            r_ram_enable      <= 1'b0;
            r_last_latch_byte <= 8'h00;
            r_boot_overlay    <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cbm_pkg::CFG_MAPPER_CODE: r_mapper_code <= i_cfg_data;
                    cbm_pkg::CFG_RAM_PRESENT: r_ram_present <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // advance bank state only with the beat that moves on
            if (i_fire) begin
                r_rom_bank        <= n_rom_bank;
                r_ram_bank        <= n_ram_bank;
                r_ram_enable      <= n_ram_enable;
                r_last_latch_byte <= n_last_latch_byte;
                r_boot_overlay    <= n_boot_overlay;
            end
        end
    end

endmodule

@@ rtl/cbm_out_reg.sv @@
`timescale 1ns / 1ps

module cbm_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  cbm_pkg::t_result i_res,
    output logic             o_ready,
    cbm_result_if.source     o_result
);

    logic             r_valid;
    cbm_pkg::t_result r_res;

    assign o_ready = !r_valid || o_result.ready;

    assign o_result.valid             = r_valid;
    assign o_result.target            = r_res.target;
    assign o_result.phys_address      = r_res.phys_address;
    assign o_result.ram_write_strobe  = r_res.ram_write_strobe;
    assign o_result.store_byte        = r_res.store_byte;
    assign o_result.force_high_nibble = r_res.force_high_nibble;
    assign o_result.latch_pulse       = r_res.latch_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/cartridge_bank_mapper.sv @@
`timescale 1ns / 1ps

// Channel    | Dir | Beat
// -----------+-----+---------------------------------------------------
// i_access   | in  | op, bus_address, write_byte (one bus access)
// o_result   | out | target, phys_address, ram_write_strobe, store_byte,
//            |     | force_high_nibble, latch_pulse
//
// One access a cycle sustained while o_result does not stall. The input register
// takes each access; decode and bank update then fill the result register.
// Reset (synchronous, active low) restores ROM bank 1, RAM bank 0, RAM off,
// latch byte 0, boot overlay on, mapper code 0 and no RAM.
// A stall on o_result backs up through both registers; each stage still
// takes a beat in the cycle its holder moves on.

module cartridge_bank_mapper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    cbm_access_if.sink                      i_access,
    cbm_result_if.source                    o_result
);

    logic             s1_valid;
    cbm_pkg::t_access s1_item;
    logic             out_ready;
    logic             fire;
    cbm_pkg::t_result res;

    assign fire = s1_valid && out_ready;

    cbm_in_reg u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_access (i_access),
        .i_take   (out_ready),
        .o_valid  (s1_valid),
        .o_item   (s1_item)
    );

    cbm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (s1_item),
        .o_res       (res)
    );

    cbm_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_res    (res),
        .o_ready  (out_ready),
        .o_result (o_result)
    );

endmodule

@@ rtl/cbm_checker.sv @@
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_assert.svh"

module cbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic [2:0]  i_target,
    input logic [22:0] i_phys_address,
    input logic        i_ram_write_strobe,
    input logic        i_force_high_nibble,
    input logic        i_latch_pulse
);

    // A store strobe only ever goes to RAM or a clock register
    `CBM_ASSERT_NOW(a_strobe_target, i_clk, i_rst_n, i_out_valid && i_ram_write_strobe, i_target == cbm_pkg::TGT_RAM || i_target == cbm_pkg::TGT_CLK)

    // The nibble fix-up is an MBC2 RAM read, never a store
    `CBM_ASSERT_NOW(a_fhn_read, i_clk, i_rst_n, i_out_valid && i_force_high_nibble, i_target == cbm_pkg::TGT_RAM && !i_ram_write_strobe)

    // A latch beat is a control write and reaches no store
    `CBM_ASSERT_NOW(a_latch_none, i_clk, i_rst_n, i_out_valid && i_latch_pulse, i_target == cbm_pkg::TGT_NONE && i_phys_address == 23'd0)

    // With the result register empty, the input side never stalls
    `CBM_ASSERT_NOW(a_no_idle_stall, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_ready          (i_access.ready),
    .i_out_valid         (o_result.valid),
    .i_target            (o_result.target),
    .i_phys_address      (o_result.phys_address),
    .i_ram_write_strobe  (o_result.ram_write_strobe),
    .i_force_high_nibble (o_result.force_high_nibble),
    .i_latch_pulse       (o_result.latch_pulse)
);
